### sv/qpe_pkg.sv
// Shared constants, types and helpers for the quoted-printable line encoder.
`default_nettype none

package qpe_pkg;

  // Character codes
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_EQ  = 8'h3D;

  // Largest tail the encoder keeps before it gives up on a space break
  localparam int TAIL_CAP_MAX = 80;

  // Configuration register map
  localparam int          CFG_AW         = 3;
  localparam logic [0:0]  REG_LINE_LIMIT = 1'b0;
  localparam logic [6:0]  LIMIT_RESET    = 7'd72;

  // Byte request from the sequencer to the chunk packer
  typedef struct packed {
    logic       vld;    // request present
    logic       close;  // end of word: flush the partial chunk
    logic       last;   // with close: chunk ends the text
    logic [7:0] data;   // encoded byte
  } pk_req_t;

  // Upper-case hex digit for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] n8;
    n8 = {4'h0, n};
    return (n < 4'd10) ? (8'h30 + n8) : (8'h37 + n8);
  endfunction

endpackage

`default_nettype wire

### sv/qpe_pack.sv
// Chunk packer: gathers encoded bytes into 8-byte chunks and holds the output register.
`default_nettype none

module qpe_pack
  import qpe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire pk_req_t     pk_req,
  output logic             pk_rdy,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_chunk,
  output logic [3:0]       out_count,
  output logic             out_tlast
);

  logic [63:0] acc_r;
  logic [3:0]  cnt_r;
  logic [63:0] out_data_r;
  logic [3:0]  out_cnt_r;
  logic        out_last_r;
  logic        out_vld_r;

  logic slot_free;
  logic fire;
  logic push;

  // Output slot frees when empty or being taken this cycle
  assign slot_free = !out_vld_r || out_tready;

  // A full chunk is pushed lazily, so the close can still mark it last
  always_comb begin
    if (pk_req.close) begin
      pk_rdy = (cnt_r == 4'd0) || slot_free;
    end else begin
      pk_rdy = (cnt_r != 4'd8) || slot_free;
    end
  end

  assign fire = pk_req.vld && pk_rdy;
  assign push = fire && (pk_req.close ? (cnt_r != 4'd0) : (cnt_r == 4'd8));

  // Accumulator and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= 4'd0;
      out_vld_r <= 1'b0;
    end else begin
      if (push) begin
        out_data_r <= acc_r;
        out_cnt_r  <= cnt_r;
        out_last_r <= pk_req.close && pk_req.last;
        out_vld_r  <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (fire) begin
        if (pk_req.close) begin
          cnt_r <= 4'd0;
        end else if ((cnt_r == 4'd0) || (cnt_r == 4'd8)) begin
          acc_r <= {56'd0, pk_req.data};
          cnt_r <= 4'd1;
        end else begin
          acc_r[{cnt_r[2:0], 3'b000} +: 8] <= pk_req.data;
          cnt_r <= cnt_r + 4'd1;
        end
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_chunk  = out_data_r;
  assign out_count  = out_cnt_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 4'd8) else $error("packer count out of range");

  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_cnt_r != 4'd0 && out_cnt_r <= 4'd8))
    else $error("chunk with bad byte count");

  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((out_data_r >> {out_cnt_r, 3'b000}) == 64'd0))
    else $error("chunk bytes above count not zero");

  a_close_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && pk_req.close) |=> (cnt_r == 4'd0))
    else $error("accumulator not empty after close");
`endif

endmodule

`default_nettype wire

### sv/qpe_ctrl.sv
// Encoding sequencer with the tail memory: classifies bytes, places soft breaks, flushes the tail.
`default_nettype none

module qpe_ctrl
  import qpe_pkg::*;
#(
  parameter int TAIL_DEPTH = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data,
  input  wire logic       in_final,
  input  wire logic [6:0] line_limit,
  output pk_req_t         pk_req,
  input  wire logic       pk_rdy
);

  localparam int CAP = (TAIL_DEPTH < TAIL_CAP_MAX) ? TAIL_DEPTH : TAIL_CAP_MAX;
  localparam int TLW = $clog2(CAP + 1);
  localparam int AW  = $clog2(TAIL_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_APPEND, S_EMIT, S_FLUSH, S_BRK_EQ, S_BRK_LF, S_AFTER, S_CLOSE
  } state_t;

  state_t           state_r;
  state_t           ret_r;
  logic [7:0]       held_byte_r;
  logic             held_valid_r;
  logic [7:0]       b_r;
  logic             fin_r;
  logic [7:0]       cur_r;
  logic [7:0]       nxt_r;
  logic             last_r;
  logic             phase_r;      // 0: held byte, 1: final byte
  logic [2:0][7:0]  e_r;
  logic [1:0]       elen_r;
  logic [1:0]       eidx_r;
  logic             brk_r;
  logic [TLW-1:0]   tail_len_r;
  logic [7:0]       column_r;
  logic             space_seen_r;
  logic [TLW-1:0]   fidx_r;
  logic             rd_pend_r;
  logic [7:0]       rdata_r;
  logic [7:0]       tail_mem [TAIL_DEPTH];

  logic       blank;
  logic       is_lf;
  logic       esc;
  logic [1:0] enc_len;
  logic       to_tail;
  logic       fits;
  logic [7:0] column_nxt;
  logic       space_nxt;
  logic       brk_nxt;
  logic       fl_more;
  logic       fl_ren;
  logic       fl_done;
  logic       wen;
  state_t     post_state;

  // Byte classification for the byte under decode
  always_comb begin
    blank   = (cur_r == CH_SP) || (cur_r == CH_TAB);
    is_lf   = (cur_r == CH_LF);
    esc     = ((cur_r < CH_LF) && (cur_r != CH_TAB)) || cur_r[7] || (cur_r == CH_EQ) ||
              (blank && !last_r && (nxt_r == CH_LF));
    enc_len = esc ? 2'd3 : 2'd1;
    to_tail = space_seen_r && !is_lf && !blank;
    fits    = ({1'b0, tail_len_r} + (TLW+1)'(enc_len)) <= (TLW+1)'(CAP);
  end

  // Column, space flag and break decision after this byte
  always_comb begin
    column_nxt = is_lf ? 8'd0 : (column_r + {6'd0, enc_len});
    if (is_lf || (to_tail && !fits)) begin
      space_nxt = 1'b0;
    end else if (blank) begin
      space_nxt = 1'b1;
    end else begin
      space_nxt = space_seen_r;
    end
    brk_nxt = !is_lf && (column_nxt >= {1'b0, line_limit}) && !last_r && (nxt_r != CH_LF);
  end

  assign post_state = brk_r ? S_BRK_EQ : S_AFTER;

  // Tail flush: one read ahead, read data held while the packer stalls
  assign fl_more = (fidx_r < tail_len_r);
  assign fl_ren  = (state_r == S_FLUSH) && fl_more && (!rd_pend_r || pk_rdy);
  assign fl_done = (state_r == S_FLUSH) && !fl_more && (!rd_pend_r || pk_rdy);
  assign wen     = (state_r == S_APPEND);

  // Requests to the packer
  always_comb begin
    pk_req = '0;
    unique case (state_r)
      S_EMIT: begin
        pk_req.vld  = 1'b1;
        pk_req.data = e_r[eidx_r];
      end
      S_FLUSH: begin
        pk_req.vld  = rd_pend_r;
        pk_req.data = rdata_r;
      end
      S_BRK_EQ: begin
        pk_req.vld  = 1'b1;
        pk_req.data = CH_EQ;
      end
      S_BRK_LF: begin
        pk_req.vld  = 1'b1;
        pk_req.data = CH_LF;
      end
      S_CLOSE: begin
        pk_req.vld   = 1'b1;
        pk_req.close = 1'b1;
        pk_req.last  = fin_r;
      end
      default: begin
        pk_req = '0;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  // Tail memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wen) begin
      tail_mem[AW'(tail_len_r)] <= e_r[eidx_r];
    end
    if (fl_ren) begin
      rdata_r <= tail_mem[AW'(fidx_r)];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      held_byte_r  <= 8'd0;
      held_valid_r <= 1'b0;
      tail_len_r   <= '0;
      column_r     <= 8'd0;
      space_seen_r <= 1'b0;
      fidx_r       <= '0;
      rd_pend_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            b_r   <= in_data;
            fin_r <= in_final;
            if (held_valid_r) begin
              cur_r   <= held_byte_r;
              nxt_r   <= in_data;
              last_r  <= 1'b0;
              phase_r <= 1'b0;
              state_r <= S_DEC;
            end else if (in_final) begin
              cur_r   <= in_data;
              nxt_r   <= 8'd0;
              last_r  <= 1'b1;
              phase_r <= 1'b1;
              state_r <= S_DEC;
            end else begin
              held_byte_r  <= in_data;
              held_valid_r <= 1'b1;
            end
          end
        end
        S_DEC: begin
          e_r[0]       <= esc ? CH_EQ : cur_r;
          e_r[1]       <= hex_char(cur_r[7:4]);
          e_r[2]       <= hex_char(cur_r[3:0]);
          elen_r       <= enc_len;
          eidx_r       <= 2'd0;
          brk_r        <= brk_nxt;
          column_r     <= column_nxt;
          space_seen_r <= space_nxt;
          if (to_tail && fits) begin
            state_r <= S_APPEND;
          end else if (tail_len_r != '0) begin
            ret_r   <= S_EMIT;
            state_r <= S_FLUSH;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_APPEND: begin
          tail_len_r <= tail_len_r + TLW'(1);
          eidx_r     <= eidx_r + 2'd1;
          if (eidx_r == elen_r - 2'd1) begin
            state_r <= post_state;
          end
        end
        S_EMIT: begin
          if (pk_rdy) begin
            eidx_r <= eidx_r + 2'd1;
            if (eidx_r == elen_r - 2'd1) begin
              state_r <= post_state;
            end
          end
        end
        S_FLUSH: begin
          if (fl_ren) begin
            fidx_r    <= fidx_r + TLW'(1);
            rd_pend_r <= 1'b1;
          end else if (pk_rdy) begin
            rd_pend_r <= 1'b0;
          end
          if (fl_done) begin
            tail_len_r <= '0;
            fidx_r     <= '0;
            state_r    <= ret_r;
          end
        end
        S_BRK_EQ: begin
          if (pk_rdy) begin
            state_r <= S_BRK_LF;
          end
        end
        S_BRK_LF: begin
          if (pk_rdy) begin
            // Bytes behind the last space open the new line
            column_r     <= space_seen_r ? 8'(tail_len_r) : 8'd0;
            space_seen_r <= 1'b0;
            if (space_seen_r && (tail_len_r != '0)) begin
              ret_r   <= S_AFTER;
              state_r <= S_FLUSH;
            end else begin
              state_r <= S_AFTER;
            end
          end
        end
        S_AFTER: begin
          if (!phase_r) begin
            if (fin_r) begin
              cur_r   <= b_r;
              nxt_r   <= 8'd0;
              last_r  <= 1'b1;
              phase_r <= 1'b1;
              state_r <= S_DEC;
            end else begin
              held_byte_r  <= b_r;
              held_valid_r <= 1'b1;
              state_r      <= S_CLOSE;
            end
          end else begin
            // End of text: drain the tail and start over
            column_r     <= 8'd0;
            space_seen_r <= 1'b0;
            held_valid_r <= 1'b0;
            held_byte_r  <= 8'd0;
            if (tail_len_r != '0) begin
              ret_r   <= S_CLOSE;
              state_r <= S_FLUSH;
            end else begin
              state_r <= S_CLOSE;
            end
          end
        end
        S_CLOSE: begin
          if (pk_rdy) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_tail_cap: assert property (@(posedge clk) disable iff (!rst_n)
    tail_len_r <= TLW'(CAP)) else $error("tail length above capacity");

  a_tail_wr: assert property (@(posedge clk) disable iff (!rst_n)
    wen |-> (tail_len_r < TLW'(CAP))) else $error("tail write past capacity");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (fidx_r == '0 && !rd_pend_r))
    else $error("flush state left over in idle");

  a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLOSE && phase_r) |-> (!held_valid_r && !space_seen_r && tail_len_r == '0))
    else $error("state not cleared at end of text");
`endif

endmodule

`default_nettype wire

### sv/quoted_printable_line_encoder_top.sv
// Output: a chunk reaches the output register when its close reaches the packer;
// longer output registers a chunk as each ninth byte enters the packer, the rest at close.
// Steps: take the word, decode, emit each encoded byte (1 or 3) or append it to the tail, the
// = and LF of a soft break, a drain of the tail, wrap-up and close; the packer can stall the emits. A
// final word adds a second decode pass. The input is ready only in idle; a held-only word keeps it ready.
// Reset (rst_n, synchronous) clears control state, sets line_limit to 72; tail memory uncleared.
`default_nettype none

module quoted_printable_line_encoder_top
  import qpe_pkg::*;
#(
  parameter int TAIL_DEPTH = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] data_byte
  input  wire logic              in_tlast,   // final_byte
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [71:0]            out_tdata,  // [63:0] chunk, [67:64] chunk_count, [71:68] zero
  output logic                   out_tlast,  // chunk_last
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [6:0]  line_limit_r;
  logic        cfg_wr;
  logic [0:0]  reg_idx;
  pk_req_t     pk_req;
  logic        pk_rdy;
  logic [63:0] out_chunk;
  logic [3:0]  out_count;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_LINE_LIMIT);
  assign prdata  = (reg_idx == REG_LINE_LIMIT) ? {25'd0, line_limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r <= LIMIT_RESET;
    end else if (cfg_wr) begin
      line_limit_r <= pwdata[6:0];
    end
  end

  qpe_ctrl #(
    .TAIL_DEPTH (TAIL_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .in_final   (in_tlast),
    .line_limit (line_limit_r),
    .pk_req     (pk_req),
    .pk_rdy     (pk_rdy)
  );

  qpe_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .pk_req     (pk_req),
    .pk_rdy     (pk_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_chunk  (out_chunk),
    .out_count  (out_count),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = {4'd0, out_count, out_chunk};

endmodule

`default_nettype wire
